// ----- design/owdm_pkg.sv -----
// ----------------------------------------------------------------------------
// owdm_pkg: shared types and constants for the omni wheel drive mixer
// Fixed-point formats, register indexes, direction codes and the beat types
// that pass between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package owdm_pkg;

   // build-time choices
   localparam int PWM_PERIOD       = 1000;   // PWM period in ticks, at most 1023 to fit TICKS_W
   localparam int ROBOT_RADIUS_Q16 = 6554;   // meters, Q0.16
   localparam bit BIDIRECTIONAL    = 1'b0;   // 1 when the weapon ESC runs both ways

   localparam int NUM_WHEELS    = 3;
   localparam int HALF_SQRT3_Q16 = 56756;
   localparam int ONE_Q15       = 32768;
   localparam int ONE_Q18       = 262144;
   localparam int DEAD_ZONE_MIN = 33;

   // x / 255 for x < 2^24 as (x * LEVEL_RECIP) >> LEVEL_SHIFT, exact
   localparam int LEVEL_SHIFT = 32;
   localparam longint LEVEL_RECIP = 64'd16843010;

   // widths
   localparam int IN_W    = 16;
   localparam int LEVEL_W = 8;
   localparam int CSR_W   = 16;
   localparam int LIM_W   = 16;            // top speed register
   localparam int U_W     = 36;            // signed wheel speed, Q.16
   localparam int ABS_W   = U_W - 1;       // magnitude of a wheel speed
   localparam int N_W     = ABS_W + 3;     // ratio dividend and quotient, Q.18
   localparam int Q_W     = 16;            // rescale quotient, Q1.15
   localparam int MAG_W   = 16;            // duty magnitude, Q1.15
   localparam int TICKS_W = 10;
   localparam int WPN_W   = 16;
   localparam int QUEUE_DEPTH = 2;         // power of two
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CSR_REVERSE_MASK = 3'd0,
      CSR_DUTY_FLOOR   = 3'd1,
      CSR_MAX_SPEED_0  = 3'd2,
      CSR_MAX_SPEED_1  = 3'd3,
      CSR_MAX_SPEED_2  = 3'd4,
      CSR_WEAPON_MIN   = 3'd5,
      CSR_WEAPON_MAX   = 3'd6,
      CSR_WEAPON_CTR   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_BRAKE   = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0]            reverse_mask;
      logic [CSR_W-1:0]                 duty_floor;
      logic [NUM_WHEELS-1:0][LIM_W-1:0] max_speed;
      logic [WPN_W-1:0]                 weapon_min;
      logic [WPN_W-1:0]                 weapon_max;
      logic [WPN_W-1:0]                 weapon_center;
   } cfg_type;

   // one classified command waiting for the back end
   typedef struct packed {
      logic [NUM_WHEELS-1:0][U_W-1:0] speed;   // signed wheel speeds
      logic [WPN_W-1:0]               weapon_ticks;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ----- design/omni_wheel_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer: three-wheel omni drive mixer with weapon pulse
// Body velocity command in, per-wheel PWM compare ticks and direction plus
// weapon ESC pulse ticks out. Front end does kinematics, back end does the
// per-wheel ratio, common rescale, duty floor and tick conversion.
// ----------------------------------------------------------------------------
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-------------------------------
//  command  | req_*                     | beat taken when start && !busy
//  result   | rsp_*                     | rsp_valid, one cycle, no stall
//  csr      | csr_index, csr_data       | write when csr_valid && csr_ready
//
// Rate: one command a cycle while busy is low. A result beat follows its command
// beat through 3 front stages, the queue slot, the divider load, 38 ratio divider
// stages, the max stage, 16 rescale divider stages, floor and tick multiply.
// Reset: synchronous; clears all valid bits, the queue and the registers to
// their defaults. busy rises only if the queue fills; the back end drains it
// every cycle since the result side cannot stall.
// csr_ready is always high. Registers are meant to change only while idle.
//
module omni_wheel_drive_mixer (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_turn_rate,
   input  logic [7:0]  req_weapon_level,
   input  logic        req_flipped,

   output logic        rsp_valid,
   output logic [9:0]  rsp_wheel0_ticks,
   output logic [1:0]  rsp_wheel0_dir,
   output logic [9:0]  rsp_wheel1_ticks,
   output logic [1:0]  rsp_wheel1_dir,
   output logic [9:0]  rsp_wheel2_ticks,
   output logic [1:0]  rsp_wheel2_dir,
   output logic [15:0] rsp_weapon_ticks,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int NW = owdm_pkg::NUM_WHEELS;

   owdm_pkg::cfg_type    cfg_ff;
   owdm_pkg::q_stat_type q_stat;
   owdm_pkg::job_type    push_data, pop_data;
   logic                 push, pop;

   logic [NW-1:0][owdm_pkg::TICKS_W-1:0] ticks;
   owdm_pkg::dir_type [NW-1:0]           dirs;

   // ---- control registers ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reverse_mask  <= '0;
         cfg_ff.duty_floor    <= '0;
         cfg_ff.max_speed[0]  <= 16'd4096;
         cfg_ff.max_speed[1]  <= 16'd4096;
         cfg_ff.max_speed[2]  <= 16'd4096;
         cfg_ff.weapon_min    <= 16'd1000;
         cfg_ff.weapon_max    <= 16'd2000;
         cfg_ff.weapon_center <= 16'd1500;
      end else if (csr_valid && csr_ready) begin
         unique case (owdm_pkg::csr_index_type'(csr_index))
            owdm_pkg::CSR_REVERSE_MASK: cfg_ff.reverse_mask  <= csr_data[NW-1:0];
            owdm_pkg::CSR_DUTY_FLOOR:   cfg_ff.duty_floor    <= csr_data;
            owdm_pkg::CSR_MAX_SPEED_0:  cfg_ff.max_speed[0]  <= csr_data;
            owdm_pkg::CSR_MAX_SPEED_1:  cfg_ff.max_speed[1]  <= csr_data;
            owdm_pkg::CSR_MAX_SPEED_2:  cfg_ff.max_speed[2]  <= csr_data;
            owdm_pkg::CSR_WEAPON_MIN:   cfg_ff.weapon_min    <= csr_data;
            owdm_pkg::CSR_WEAPON_MAX:   cfg_ff.weapon_max    <= csr_data;
            owdm_pkg::CSR_WEAPON_CTR:   cfg_ff.weapon_center <= csr_data;
         endcase
      end
   end

   // ---- front end: intake, flip, kinematics, weapon pulse ----
   owdm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_vel_x        (req_vel_x),
      .req_vel_y        (req_vel_y),
      .req_turn_rate    (req_turn_rate),
      .req_weapon_level (req_weapon_level),
      .req_flipped      (req_flipped),
      .cfg              (cfg_ff),
      .q_stat           (q_stat),
      .push             (push),
      .push_data        (push_data)
   );

   // ---- job queue ----
   owdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // ---- back end: ratio, rescale, floor, ticks ----
   owdm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_stat           (q_stat),
      .pop              (pop),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ticks        (ticks),
      .rsp_dir          (dirs),
      .rsp_weapon_ticks (rsp_weapon_ticks)
   );

   assign rsp_wheel0_ticks = ticks[0];
   assign rsp_wheel1_ticks = ticks[1];
   assign rsp_wheel2_ticks = ticks[2];
   assign rsp_wheel0_dir   = dirs[0];
   assign rsp_wheel1_dir   = dirs[1];
   assign rsp_wheel2_dir   = dirs[2];

   // ---- checks ----
   localparam logic [15:0] PERIOD_MAX = 16'(owdm_pkg::PWM_PERIOD);
   // a braked wheel has magnitude under the dead zone, so its ticks are tiny
   localparam logic [9:0] BRAKE_TICKS_MAX =
      10'(((owdm_pkg::DEAD_ZONE_MIN - 1) * owdm_pkg::PWM_PERIOD) / owdm_pkg::ONE_Q15);

   a_ticks_in_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({6'b0, rsp_wheel0_ticks} <= PERIOD_MAX &&
                     {6'b0, rsp_wheel1_ticks} <= PERIOD_MAX &&
                     {6'b0, rsp_wheel2_ticks} <= PERIOD_MAX))
      else $error("wheel ticks beyond PWM period");

   a_brake_ticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_wheel0_dir != owdm_pkg::DIR_BRAKE || rsp_wheel0_ticks <= BRAKE_TICKS_MAX) &&
          (rsp_wheel1_dir != owdm_pkg::DIR_BRAKE || rsp_wheel1_ticks <= BRAKE_TICKS_MAX) &&
          (rsp_wheel2_dir != owdm_pkg::DIR_BRAKE || rsp_wheel2_ticks <= BRAKE_TICKS_MAX)))
      else $error("braked wheel with large duty");

   a_no_beat_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !busy)
      else $error("busy right after reset");

endmodule

// ----- design/owdm_front.sv -----
// ----------------------------------------------------------------------------
// owdm_front: command intake and inverse kinematics
// Takes a command beat, applies the flip, forms the three wheel speeds and
// the weapon pulse, and pushes one job into the queue.
// ----------------------------------------------------------------------------
module owdm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [owdm_pkg::IN_W-1:0]  req_vel_x,
   input  logic signed [owdm_pkg::IN_W-1:0]  req_vel_y,
   input  logic signed [owdm_pkg::IN_W-1:0]  req_turn_rate,
   input  logic [owdm_pkg::LEVEL_W-1:0]      req_weapon_level,
   input  logic                              req_flipped,
   input  owdm_pkg::cfg_type                 cfg,
   input  owdm_pkg::q_stat_type              q_stat,
   output logic                              push,
   output owdm_pkg::job_type                 push_data
);

   localparam int U_W   = owdm_pkg::U_W;
   localparam int WPN_W = owdm_pkg::WPN_W;
   localparam logic signed [17:0] HALF_K   = 18'(owdm_pkg::HALF_SQRT3_Q16);
   localparam logic signed [17:0] RADIUS_K = 18'(owdm_pkg::ROBOT_RADIUS_Q16);
   localparam logic [24:0]        RECIP_K  = 25'(owdm_pkg::LEVEL_RECIP);

   logic adv;
   logic accept;

   // stage 0: captured command
   logic               s0_valid_ff;
   logic signed [16:0] s0_vx_ff, s0_vx_in;
   logic signed [15:0] s0_vy_ff;
   logic signed [15:0] s0_w_ff;
   logic [7:0]         s0_level_ff;
   logic               s0_flip_ff;

   // stage 1: products
   logic               s1_valid_ff;
   logic signed [34:0] s1_pvx_ff, s1_pvx_in;
   logic signed [33:0] s1_prw_ff, s1_prw_in;
   logic signed [15:0] s1_vy_ff;
   logic [WPN_W-1:0]   s1_base_ff, s1_base_in;
   logic               s1_down_ff, s1_down_in;
   logic [23:0]        s1_wprod_ff, s1_wprod_in;
   logic [WPN_W-1:0]   s1_far_in, s1_span_in;

   // stage 2: wheel speeds and weapon step
   logic                 s2_valid_ff;
   logic signed [U_W-1:0] s2_u0_ff, s2_u1_ff, s2_u2_ff;
   logic signed [U_W-1:0] s2_u0_in, s2_u1_in, s2_u2_in;
   logic signed [U_W-1:0] pvx_ext, vy_full, vy_half, rw8;
   logic [WPN_W-1:0]     s2_base_ff;
   logic                 s2_down_ff;
   logic [WPN_W-1:0]     s2_step_ff;
   logic [48:0]          s2_recip_in;

   assign adv    = !q_stat.full;
   assign busy   = q_stat.full;
   assign accept = start && !busy;

   assign s0_vx_in = req_flipped ? -{req_vel_x[15], req_vel_x} : {req_vel_x[15], req_vel_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_vx_ff    <= s0_vx_in;
         s0_vy_ff    <= req_vel_y;
         s0_w_ff     <= req_turn_rate;
         s0_level_ff <= req_weapon_level;
         s0_flip_ff  <= req_flipped;
      end
   end

   // weapon endpoints: base is where level 0 sits, far where level 255 sits
   always_comb begin
      if (owdm_pkg::BIDIRECTIONAL) begin
         s1_base_in = cfg.weapon_center;
         s1_far_in  = s0_flip_ff ? cfg.weapon_min : cfg.weapon_max;
      end else begin
         s1_base_in = cfg.weapon_min;
         s1_far_in  = cfg.weapon_max;
      end
      s1_down_in  = s1_far_in < s1_base_in;
      s1_span_in  = s1_down_in ? s1_base_in - s1_far_in : s1_far_in - s1_base_in;
      s1_wprod_in = {16'b0, s0_level_ff} * {8'b0, s1_span_in};
   end

   assign s1_pvx_in = s0_vx_ff * HALF_K;
   assign s1_prw_in = s0_w_ff * RADIUS_K;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pvx_ff   <= s1_pvx_in;
         s1_prw_ff   <= s1_prw_in;
         s1_vy_ff    <= s0_vy_ff;
         s1_base_ff  <= s1_base_in;
         s1_down_ff  <= s1_down_in;
         s1_wprod_ff <= s1_wprod_in;
      end
   end

   assign pvx_ext = {s1_pvx_ff[34], s1_pvx_ff};
   assign vy_full = {{4{s1_vy_ff[15]}}, s1_vy_ff, 16'b0};
   assign vy_half = {{5{s1_vy_ff[15]}}, s1_vy_ff, 15'b0};
   assign rw8     = {s1_prw_ff[32:0], 3'b000};   // |w*R| < 2^32

   assign s2_u0_in = rw8 - vy_full;
   assign s2_u1_in = pvx_ext + vy_half + rw8;
   assign s2_u2_in = vy_half + rw8 - pvx_ext;

   assign s2_recip_in = {25'b0, s1_wprod_ff} * {24'b0, RECIP_K};

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_u0_ff   <= s2_u0_in;
         s2_u1_ff   <= s2_u1_in;
         s2_u2_ff   <= s2_u2_in;
         s2_base_ff <= s1_base_ff;
         s2_down_ff <= s1_down_ff;
         s2_step_ff <= s2_recip_in[owdm_pkg::LEVEL_SHIFT +: WPN_W];
      end
   end

   assign push = s2_valid_ff && adv;
   assign push_data.speed[0] = s2_u0_ff;
   assign push_data.speed[1] = s2_u1_ff;
   assign push_data.speed[2] = s2_u2_ff;
   assign push_data.weapon_ticks = s2_down_ff ? s2_base_ff - s2_step_ff
                                              : s2_base_ff + s2_step_ff;

endmodule

// ----- design/owdm_queue.sv -----
// ----------------------------------------------------------------------------
// owdm_queue: short job queue between front end and back end
// Register-based FIFO, one push and one pop a cycle; a push while full or a pop while empty is ignored.
// ----------------------------------------------------------------------------
module owdm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  owdm_pkg::job_type    push_data,
   input  logic                 pop,
   output owdm_pkg::job_type    pop_data,
   output owdm_pkg::q_stat_type q_stat
);

   localparam int QPTR_W = owdm_pkg::QPTR_W;

   owdm_pkg::job_type  slot_ff [owdm_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.full  = count_ff == (QPTR_W+1)'(owdm_pkg::QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

// ----- design/owdm_back.sv -----
// ----------------------------------------------------------------------------
// owdm_back: ratio, rescale, duty floor and tick conversion
// Two pipelined restoring dividers (speed over top speed, then rescale by
// the largest ratio when it exceeds one), then the duty floor, direction and PWM ticks.
// ----------------------------------------------------------------------------
module owdm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  owdm_pkg::cfg_type                 cfg,
   input  owdm_pkg::q_stat_type              q_stat,
   output logic                              pop,
   input  owdm_pkg::job_type                 pop_data,
   output logic                              rsp_valid,
   output logic [owdm_pkg::NUM_WHEELS-1:0][owdm_pkg::TICKS_W-1:0] rsp_ticks,
   output owdm_pkg::dir_type [owdm_pkg::NUM_WHEELS-1:0]           rsp_dir,
   output logic [owdm_pkg::WPN_W-1:0]        rsp_weapon_ticks
);

   localparam int NW    = owdm_pkg::NUM_WHEELS;
   localparam int U_W   = owdm_pkg::U_W;
   localparam int ABS_W = owdm_pkg::ABS_W;
   localparam int N_W   = owdm_pkg::N_W;
   localparam int LIM_W = owdm_pkg::LIM_W;
   localparam int Q_W   = owdm_pkg::Q_W;
   localparam int MAG_W = owdm_pkg::MAG_W;
   localparam int WPN_W = owdm_pkg::WPN_W;
   localparam int TK_W  = owdm_pkg::TICKS_W;
   localparam logic [N_W-1:0]   ONE_R   = N_W'(owdm_pkg::ONE_Q18);
   localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(owdm_pkg::ONE_Q15);
   localparam logic [MAG_W-1:0] DZ_MIN  = MAG_W'(owdm_pkg::DEAD_ZONE_MIN);
   localparam logic [MAG_W-1:0] PERIOD  = MAG_W'(owdm_pkg::PWM_PERIOD);

   logic [NW-1:0][LIM_W-1:0] lim;

   // first divider: r = |u| * 8 / lim, one quotient bit a stage
   logic             d1_valid_ff [0:N_W];
   logic [WPN_W-1:0] d1_wpn_ff   [0:N_W];
   logic [LIM_W-1:0] d1_rem_ff   [NW][0:N_W];
   logic [N_W-1:0]   d1_nq_ff    [NW][0:N_W];
   logic             d1_neg_ff   [NW][0:N_W];

   // second divider: mag = r * 2^15 / maxr
   logic             d2_valid_ff [0:Q_W];
   logic [WPN_W-1:0] d2_wpn_ff   [0:Q_W];
   logic [N_W-1:0]   d2_max_ff   [0:Q_W];
   logic [N_W-1:0]   d2_max_in;
   logic [N_W-1:0]   d2_rem_ff   [NW][0:Q_W];
   logic [Q_W-1:0]   d2_nq_ff    [NW][0:Q_W];
   logic [MAG_W-1:0] d2_small_ff [NW][0:Q_W];
   logic             d2_neg_ff   [NW][0:Q_W];

   // floor and direction
   logic              f_valid_ff;
   logic [WPN_W-1:0]  f_wpn_ff;
   logic [MAG_W-1:0]  f_mag_ff [NW];
   owdm_pkg::dir_type f_dir_ff [NW];
   logic              f_big;
   logic [MAG_W-1:0]  md;

   logic rsp_valid_ff;
   logic [NW-1:0][TK_W-1:0]            rsp_ticks_ff;
   owdm_pkg::dir_type [NW-1:0]         rsp_dir_ff;
   logic [WPN_W-1:0]                   rsp_wpn_ff;

   assign pop = !q_stat.empty;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         lim[i] = (cfg.max_speed[i] == '0) ? LIM_W'(1) : cfg.max_speed[i];
      end
   end

   // ---- entry ----
   always_ff @(posedge clock) begin
      if (reset) d1_valid_ff[0] <= 1'b0;
      else d1_valid_ff[0] <= pop;
   end

   always_ff @(posedge clock) begin
      d1_wpn_ff[0] <= pop_data.weapon_ticks;
   end

   for (genvar i = 0; i < NW; i++) begin : g_entry
      logic [U_W-1:0] abs_in;
      assign abs_in = pop_data.speed[i][U_W-1] ? -pop_data.speed[i] : pop_data.speed[i];
      always_ff @(posedge clock) begin
         d1_rem_ff[i][0] <= '0;
         d1_nq_ff[i][0]  <= {abs_in[ABS_W-1:0], 3'b000};
         d1_neg_ff[i][0] <= pop_data.speed[i][U_W-1];
      end
   end

   // ---- first divider ----
   for (genvar k = 1; k <= N_W; k++) begin : g_div1
      always_ff @(posedge clock) begin
         if (reset) d1_valid_ff[k] <= 1'b0;
         else d1_valid_ff[k] <= d1_valid_ff[k-1];
      end
      always_ff @(posedge clock) begin
         d1_wpn_ff[k] <= d1_wpn_ff[k-1];
      end
      for (genvar i = 0; i < NW; i++) begin : g_w
         logic [LIM_W:0] t_in, diff_in;
         logic           ge_in;
         assign t_in    = {d1_rem_ff[i][k-1], d1_nq_ff[i][k-1][N_W-1]};
         assign ge_in   = t_in >= {1'b0, lim[i]};
         assign diff_in = t_in - {1'b0, lim[i]};
         always_ff @(posedge clock) begin
            d1_rem_ff[i][k] <= ge_in ? diff_in[LIM_W-1:0] : t_in[LIM_W-1:0];
            d1_nq_ff[i][k]  <= {d1_nq_ff[i][k-1][N_W-2:0], ge_in};
            d1_neg_ff[i][k] <= d1_neg_ff[i][k-1];
         end
      end
   end

   // ---- largest ratio, second divider load ----
   always_comb begin
      d2_max_in = d1_nq_ff[0][N_W];
      for (int i = 1; i < NW; i++) begin
         if (d1_nq_ff[i][N_W] > d2_max_in) d2_max_in = d1_nq_ff[i][N_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d2_valid_ff[0] <= 1'b0;
      else d2_valid_ff[0] <= d1_valid_ff[N_W];
   end

   always_ff @(posedge clock) begin
      d2_wpn_ff[0] <= d1_wpn_ff[N_W];
      d2_max_ff[0] <= d2_max_in;
   end

   // r * 2^15 split: top part r >> 1 seeds the remainder, r[0] leads the rest
   for (genvar i = 0; i < NW; i++) begin : g_load2
      always_ff @(posedge clock) begin
         d2_rem_ff[i][0]   <= {1'b0, d1_nq_ff[i][N_W][N_W-1:1]};
         d2_nq_ff[i][0]    <= {d1_nq_ff[i][N_W][0], {(Q_W-1){1'b0}}};
         d2_small_ff[i][0] <= d1_nq_ff[i][N_W][3 +: MAG_W];
         d2_neg_ff[i][0]   <= d1_neg_ff[i][N_W];
      end
   end

   // ---- second divider ----
   for (genvar k = 1; k <= Q_W; k++) begin : g_div2
      always_ff @(posedge clock) begin
         if (reset) d2_valid_ff[k] <= 1'b0;
         else d2_valid_ff[k] <= d2_valid_ff[k-1];
      end
      always_ff @(posedge clock) begin
         d2_wpn_ff[k] <= d2_wpn_ff[k-1];
         d2_max_ff[k] <= d2_max_ff[k-1];
      end
      for (genvar i = 0; i < NW; i++) begin : g_w
         logic [N_W:0] t_in, diff_in;
         logic         ge_in;
         assign t_in    = {d2_rem_ff[i][k-1], d2_nq_ff[i][k-1][Q_W-1]};
         assign ge_in   = t_in >= {1'b0, d2_max_ff[k-1]};
         assign diff_in = t_in - {1'b0, d2_max_ff[k-1]};
         always_ff @(posedge clock) begin
            d2_rem_ff[i][k]   <= ge_in ? diff_in[N_W-1:0] : t_in[N_W-1:0];
            d2_nq_ff[i][k]    <= {d2_nq_ff[i][k-1][Q_W-2:0], ge_in};
            d2_small_ff[i][k] <= d2_small_ff[i][k-1];
            d2_neg_ff[i][k]   <= d2_neg_ff[i][k-1];
         end
      end
   end

   // ---- duty floor and direction ----
   assign f_big = d2_max_ff[Q_W] > ONE_R;
   assign md    = (cfg.duty_floor > ONE_MAG) ? ONE_MAG : cfg.duty_floor;

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else f_valid_ff <= d2_valid_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      f_wpn_ff <= d2_wpn_ff[Q_W];
   end

   for (genvar i = 0; i < NW; i++) begin : g_floor
      logic [MAG_W-1:0] mag_in;
      logic             live_in;
      assign mag_in  = f_big ? d2_nq_ff[i][Q_W] : d2_small_ff[i][Q_W];
      assign live_in = mag_in >= DZ_MIN;
      always_ff @(posedge clock) begin
         f_mag_ff[i] <= (live_in && mag_in < md) ? md : mag_in;
         if (!live_in) f_dir_ff[i] <= owdm_pkg::DIR_BRAKE;
         else if (d2_neg_ff[i][Q_W] ^ cfg.reverse_mask[i]) f_dir_ff[i] <= owdm_pkg::DIR_REVERSE;
         else f_dir_ff[i] <= owdm_pkg::DIR_FORWARD;
      end
   end

   // ---- ticks ----
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= f_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_wpn_ff <= f_wpn_ff;
   end

   for (genvar i = 0; i < NW; i++) begin : g_ticks
      logic [2*MAG_W-1:0] prod_in;
      assign prod_in = {{MAG_W{1'b0}}, f_mag_ff[i]} * {{MAG_W{1'b0}}, PERIOD};
      always_ff @(posedge clock) begin
         rsp_ticks_ff[i] <= prod_in[15 +: TK_W];
         rsp_dir_ff[i]   <= f_dir_ff[i];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ticks        = rsp_ticks_ff;
   assign rsp_dir          = rsp_dir_ff;
   assign rsp_weapon_ticks = rsp_wpn_ff;

endmodule
